[rtl/clce_pkg.sv]
package clce_pkg;

    localparam int SUM_W  = 8;
    localparam int COL_W  = 4;
    localparam int LINE_W = 5;

    typedef enum logic [1:0] {
        SEC_CMD   = 2'd0,
        SEC_CLOCK = 2'd1,
        SEC_TIMER = 2'd2,
        SEC_ASTRO = 2'd3
    } t_section;

    // Message kinds; code 3 behaves like the full timer message.
    localparam logic [1:0] KIND_CMD_ONLY  = 2'd0;
    localparam logic [1:0] KIND_CLOCK     = 2'd1;
    localparam logic [1:0] KIND_FULL      = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_CREATE_MODE  = 1'b0;
    localparam logic CFG_MESSAGE_KIND = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_message;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       check_position;
        logic       check_mismatch;
        logic       message_end;
        logic       message_good;
        logic       beyond_end;
    } t_out_item;

    typedef struct packed {
        logic       index;
        logic [1:0] value;
    } t_cfg_wr;

    typedef struct packed {
        logic [SUM_W-1:0]  running_sum;
        logic [COL_W-1:0]  column_count;
        logic [LINE_W-1:0] line_count;
        t_section          section;
        logic              error_seen;
        logic              ended;
    } t_state;

endpackage

[rtl/clce_if.sv]
interface clce_in_if;
    logic               valid;
    logic               ready;
    clce_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface clce_out_if;
    logic                valid;
    logic                ready;
    clce_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface clce_cfg_if;
    logic              valid;
    logic              ready;
    clce_pkg::t_cfg_wr data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/clce_step.sv]
module clce_step #(
    parameter int CMD_BYTES   = 6,
    parameter int LINE_BYTES  = 9,
    parameter int TIMER_LINES = 4,
    parameter int ASTRO_LINES = 12
) (
    input  clce_pkg::t_in_item  i_item,
    input  clce_pkg::t_state    i_state,
    input  logic                i_create,
    input  logic [1:0]          i_kind,
    output clce_pkg::t_state    o_state,
    output clce_pkg::t_out_item o_result
);
    import clce_pkg::*;

    localparam logic [COL_W:0]  CMD_LEN   = (COL_W+1)'(CMD_BYTES);
    localparam logic [COL_W:0]  LINE_LEN  = (COL_W+1)'(LINE_BYTES);
    localparam logic [LINE_W:0] TIMER_CNT = (LINE_W+1)'(TIMER_LINES);
    localparam logic [LINE_W:0] ASTRO_CNT = (LINE_W+1)'(ASTRO_LINES);

    t_state            cur;
    logic              active;
    logic              is_check;
    logic              mismatch;
    logic              finish;
    logic [SUM_W-1:0]  ob;
    logic [LINE_W:0]   line_inc;

    // A first byte restarts the message before it is processed.
    assign cur = i_item.first_of_message ? '0 : i_state;

    assign active   = !cur.ended;
    assign is_check = active && (({1'b0, cur.column_count} + 1'b1) ==
                      ((cur.section == SEC_CMD) ? CMD_LEN : LINE_LEN));
    assign ob       = (is_check && i_create) ? cur.running_sum : i_item.data_byte;
    assign mismatch = is_check && !i_create && (i_item.data_byte != cur.running_sum);
    assign line_inc = {1'b0, cur.line_count} + 1'b1;
    assign finish   = is_check && (
                      ((cur.section == SEC_CMD)   && (i_kind == KIND_CMD_ONLY)) ||
                      ((cur.section == SEC_CLOCK) && (i_kind == KIND_CLOCK))    ||
                      ((cur.section == SEC_ASTRO) && (line_inc >= ASTRO_CNT)));

    always_comb begin
        o_state = cur;
        if (active) begin
            o_state.running_sum = cur.running_sum + ob;
            o_state.error_seen  = cur.error_seen | mismatch;
            o_state.ended       = finish;
            if (is_check) begin
                o_state.column_count = '0;
                unique case (cur.section)
                    SEC_CMD: begin
                        if (i_kind != KIND_CMD_ONLY) begin
                            o_state.section = SEC_CLOCK;
                        end
                    end
                    SEC_CLOCK: begin
                        if (i_kind != KIND_CLOCK) begin
                            o_state.section    = SEC_TIMER;
                            o_state.line_count = '0;
                        end
                    end
                    SEC_TIMER: begin
                        if (line_inc >= TIMER_CNT) begin
                            o_state.section    = SEC_ASTRO;
                            o_state.line_count = '0;
                        end else begin
                            o_state.line_count = line_inc[LINE_W-1:0];
                        end
                    end
                    SEC_ASTRO: begin
                        o_state.line_count = line_inc[LINE_W-1:0];
                    end
                    default: begin
                        o_state.section = SEC_CMD;
                    end
                endcase
            end else begin
                o_state.column_count = cur.column_count + 1'b1;
            end
        end
    end

    always_comb begin
        o_result.out_byte       = ob;
        o_result.check_position = is_check;
        o_result.check_mismatch = mismatch;
        o_result.message_end    = finish;
        o_result.message_good   = !(cur.error_seen | mismatch);
        o_result.beyond_end     = !active;
    end

endmodule

[rtl/chained_line_checksum_engine.sv]
// Checksum engine for chained-line programming messages.
// The input channel carries one message byte per transfer, with a flag that
// marks the first byte of a new message. The output channel returns one
// result per byte: the byte itself (or, in create mode, the computed sum at
// each check position) together with check, mismatch, end and status flags.
// The configuration channel writes register 0 (create mode) and register 1
// (message kind); it is always ready and should be used only while idle.
// Output valid rises in the cycle after an input transfer. One byte is
// accepted every cycle while the receiver takes results; the running sum
// add and the column compare sit between the stored message state and the
// output register. The output register frees itself in the same cycle it
// is taken, so input ready stays high while the receiver takes results.
// When the receiver stalls, input ready drops and the pending result holds.
// Reset clears the message state, selects verify mode and the full timer
// message kind, and empties the output register.
module chained_line_checksum_engine #(
    parameter int CMD_BYTES   = 6,
    parameter int LINE_BYTES  = 9,
    parameter int TIMER_LINES = 4,
    parameter int ASTRO_LINES = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    clce_in_if.sink           i_in,
    clce_out_if.source        o_out,
    clce_cfg_if.sink          i_cfg
);
    import clce_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic       r_create;
    logic [1:0] r_kind;
    logic       r_out_valid;
    t_out_item  r_out;
    t_out_item  n_out;
    logic       in_xfer;
    logic       cfg_xfer;

    clce_step #(
        .CMD_BYTES   (CMD_BYTES),
        .LINE_BYTES  (LINE_BYTES),
        .TIMER_LINES (TIMER_LINES),
        .ASTRO_LINES (ASTRO_LINES)
    ) u_step (
        .i_item   (i_in.data),
        .i_state  (r_state),
        .i_create (r_create),
        .i_kind   (r_kind),
        .o_state  (n_state),
        .o_result (n_out)
    );

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_xfer    = i_cfg.valid;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_create <= 1'b0;
            r_kind   <= KIND_FULL;
        end else if (cfg_xfer) begin
            unique case (i_cfg.data.index)
                CFG_CREATE_MODE:  r_create <= i_cfg.data.value[0];
                CFG_MESSAGE_KIND: r_kind   <= i_cfg.data.value;
                default:          r_kind   <= r_kind;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out <= n_out;
        end
    end

endmodule
